[rtl/sbcg_pkg.sv]
// Shared types and codes for the sound board control glue.
package sbcg_pkg;

    // Item kinds on the input channel
    localparam logic [3:0] KIND_TICK      = 4'd0;
    localparam logic [3:0] KIND_COMMAND   = 4'd1;
    localparam logic [3:0] KIND_RATE      = 4'd2;
    localparam logic [3:0] KIND_CONTROL   = 4'd3;
    localparam logic [3:0] KIND_AY_LATCH  = 4'd4;
    localparam logic [3:0] KIND_DAC_VOL   = 4'd5;
    localparam logic [3:0] KIND_DAC_DATA  = 4'd6;
    localparam logic [3:0] KIND_YM_WRITE  = 4'd7;
    localparam logic [3:0] KIND_DAC_NMI   = 4'd8;

    // Event codes on the result channel
    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_SOUND_NMI   = 3'd1;
    localparam logic [2:0] EV_CMD_IRQ     = 3'd2;
    localparam logic [2:0] EV_AY_WRITE    = 3'd3;
    localparam logic [2:0] EV_DAC_UPDATE  = 3'd4;
    localparam logic [2:0] EV_YM_WRITE    = 3'd5;
    localparam logic [2:0] EV_DAC_NMI     = 3'd6;

    // Board generation modes
    localparam logic MODE_AY = 1'b0;
    localparam logic MODE_YM = 1'b1;

    localparam logic [5:0] CMD_MASK      = 6'h3f;
    localparam logic [3:0] CMD_IGNORE    = 4'hf;
    localparam logic [8:0] TIMER_FULL    = 9'd256;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [15:0] value;
        logic        ay_chip;
        logic        ay_is_address;
        logic        ym_is_data;
    } t_result;

endpackage

[rtl/sbcg_core.sv]
// Board state and combinational decode of one bus write or tick.
module sbcg_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic            i_mode,
    input  sbcg_pkg::t_item i_item,
    output sbcg_pkg::t_result o_result
);
    import sbcg_pkg::*;

    logic [7:0] r_rate,   n_rate;
    logic [7:0] r_ay_lat, n_ay_lat;
    logic       r_strobe, n_strobe;
    logic       r_run,    n_run;
    logic [8:0] r_period, n_period;
    logic [8:0] r_remain, n_remain;
    logic [7:0] r_vol,    n_vol;
    logic [7:0] r_smp,    n_smp;
    logic       r_ym_sel, n_ym_sel;

    logic [5:0]  cmd;
    logic [15:0] product;
    logic [7:0]  d;

    assign d       = i_item.data;
    assign cmd     = (~d[5:0]) & CMD_MASK;
    // DAC product uses the volume/sample after this beat's update
    assign product = 16'(n_vol) * 16'(n_smp);

    always_comb begin
        n_rate   = r_rate;
        n_ay_lat = r_ay_lat;
        n_strobe = r_strobe;
        n_run    = r_run;
        n_period = r_period;
        n_remain = r_remain;
        n_vol    = r_vol;
        n_smp    = r_smp;
        n_ym_sel = r_ym_sel;
        o_result = '0;
        case (i_item.kind)
            KIND_TICK: begin
                if (r_run) begin
                    if (r_remain <= 9'd1) begin
                        n_remain           = r_period;
                        o_result.event_res = EV_SOUND_NMI;
                    end else begin
                        n_remain = r_remain - 9'd1;
                    end
                end
            end
            KIND_COMMAND: begin
                if (cmd[3:0] != CMD_IGNORE) begin
                    o_result.event_res = EV_CMD_IRQ;
                    o_result.value     = 16'(cmd);
                end
            end
            KIND_RATE: n_rate = d;
            KIND_CONTROL: begin
                n_run = 1'b0;
                if (d[0]) begin
                    n_period = TIMER_FULL - {1'b0, r_rate};
                    n_remain = TIMER_FULL - {1'b0, r_rate};
                    n_run    = 1'b1;
                end
                if (i_mode == MODE_AY) begin
                    if (r_strobe && !d[2]) begin
                        o_result.event_res     = EV_AY_WRITE;
                        o_result.value         = 16'(r_ay_lat);
                        o_result.ay_chip       = ~d[3];
                        o_result.ay_is_address = d[4];
                    end
                    n_strobe = d[2];
                end else begin
                    n_ym_sel = d[7];
                end
            end
            KIND_AY_LATCH: n_ay_lat = d;
            KIND_DAC_VOL: begin
                n_vol              = ~d;
                o_result.event_res = EV_DAC_UPDATE;
                o_result.value     = product;
            end
            KIND_DAC_DATA: begin
                n_smp              = d;
                o_result.event_res = EV_DAC_UPDATE;
                o_result.value     = product;
            end
            KIND_YM_WRITE: begin
                o_result.event_res  = EV_YM_WRITE;
                o_result.value      = 16'(d);
                o_result.ym_is_data = r_ym_sel;
            end
            KIND_DAC_NMI: o_result.event_res = EV_DAC_NMI;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= '0;
            r_ay_lat <= '0;
            r_strobe <= 1'b0;
            r_run    <= 1'b0;
            r_period <= TIMER_FULL;
            r_remain <= TIMER_FULL;
            r_vol    <= '0;
            r_smp    <= '0;
            r_ym_sel <= 1'b0;
        end else if (i_fire) begin
            r_rate   <= n_rate;
            r_ay_lat <= n_ay_lat;
            r_strobe <= n_strobe;
            r_run    <= n_run;
            r_period <= n_period;
            r_remain <= n_remain;
            r_vol    <= n_vol;
            r_smp    <= n_smp;
            r_ym_sel <= n_ym_sel;
        end
    end

    // Countdown always sits in 1..period
    a_remain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remain != 9'd0 && r_remain <= r_period)
        else $error("timer remaining out of range");

    // Period never exceeds a full 256-tick cycle and is never zero
    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_period != 9'd0 && r_period <= TIMER_FULL)
        else $error("timer period out of range");

    // State only moves on a processed beat
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_remain) && $stable(r_run) && $stable(r_strobe))
        else $error("state changed without a beat");

endmodule

[rtl/sound_board_control_glue_unit.sv]
// Top level of the sound board control glue: handshakes, mode register, result register.
// Flow: an accepted beat waits in the input register while it is decoded; its result is then
//   loaded into the result register and offered on o_out_valid until the sink takes it.
// Throughput: one beat per cycle while the sink does not stall; set by the single decode
//   stage feeding the result register, with the 8x8 DAC multiply as the longest path.
// Reset (i_rst_n low, synchronous): both stages empty, mode 0, timer stopped
//   with a 256-tick period, all latches and DAC registers zero.
module sound_board_control_glue_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    input  sbcg_pkg::t_item    i_in_data,
    output logic               o_in_stall,
    // result channel
    output logic               o_out_valid,
    output sbcg_pkg::t_result  o_out_data,
    input  logic               i_out_stall,
    // mode register write
    input  logic               i_cfg_valid,
    input  logic               i_cfg_data,
    output logic               o_cfg_ready
);
    import sbcg_pkg::*;

    // Input register: holds the beat being decoded this cycle
    logic    r_in_valid;
    t_item   r_in_item;
    // Result register: holds the finished beat until the sink takes it
    logic    r_out_valid;
    t_result r_out_data;
    logic    r_mode;

    logic    out_free;   // result register can be loaded this cycle
    logic    fire;       // decode the beat in the input register
    logic    in_take;    // accept a new beat into the input register
    t_result result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    // Input register frees up whenever its beat moves on to the result register
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    sbcg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_mode   (r_mode),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_AY;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_data;
        end
        if (fire) begin
            r_out_data <= result;
        end
    end

    // A stalled beat in the input register is never dropped
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_in_stall |=> r_in_valid && $stable(r_in_item))
        else $error("input beat lost while stalled");

    // AY selects only ride on an AY write
    a_ay_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_data.ay_chip || r_out_data.ay_is_address)
        |-> r_out_data.event_res == EV_AY_WRITE)
        else $error("AY select on non-AY event");

    // YM port bit only rides on a YM write
    a_ym_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.ym_is_data |-> r_out_data.event_res == EV_YM_WRITE)
        else $error("YM port bit on non-YM event");

    // Every decoded beat lands in the result register
    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("decoded beat not registered");

endmodule
